FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SPSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define SPSE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/core/spse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse symbol encoder package
// Field widths, sequencer step addresses, control word layout and microcode.
// ----------------------------------------------------------------------------
package spse_pkg;

  localparam int STEPS_W       = 7;
  localparam int SPAN_W        = 16;
  localparam int FIRST_W       = 15;
  localparam int SECOND_W      = 16;
  localparam int REM_W         = 7;
  localparam int DIV_W         = SPAN_W + 1;
  localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
  localparam int DEF_MAX_STEPS = 64;
  localparam int PC_W          = 3;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t A_IDLE  = pc_t'(0);
  localparam pc_t A_CHECK = pc_t'(1);
  localparam pc_t A_TEST  = pc_t'(2);
  localparam pc_t A_DINIT = pc_t'(3);
  localparam pc_t A_DSTEP = pc_t'(4);
  localparam pc_t A_EVAL  = pc_t'(5);
  localparam pc_t A_FLUSH = pc_t'(6);
  localparam pc_t A_PAUSE = pc_t'(7);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_EVAL,
    OP_PAUSE,
    OP_FLUSH
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_DONE,
    C_PAUSE,
    C_DIV_MORE,
    C_Q_NONZERO
  } cond_e;

  typedef struct packed {
    op_e   op;
    logic  wait_in;
    logic  wait_out;
    cond_e cond;
    pc_t   target;
  } ctl_word_t;

  // Control store: jump to target when the condition holds, else fall through.
  function automatic ctl_word_t ucode(pc_t addr);
    ctl_word_t w;
    w = '{op: OP_NONE, wait_in: 1'b0, wait_out: 1'b0, cond: C_ALWAYS, target: A_IDLE};
    case (addr)
      A_IDLE:  w = '{op: OP_LOAD,    wait_in: 1'b1, wait_out: 1'b0,
                     cond: C_NEXT,      target: A_IDLE};
      A_CHECK: w = '{op: OP_NONE,    wait_in: 1'b0, wait_out: 1'b0,
                     cond: C_DONE,      target: A_FLUSH};
      A_TEST:  w = '{op: OP_NONE,    wait_in: 1'b0, wait_out: 1'b0,
                     cond: C_PAUSE,     target: A_PAUSE};
      A_DINIT: w = '{op: OP_DIVINIT, wait_in: 1'b0, wait_out: 1'b0,
                     cond: C_NEXT,      target: A_IDLE};
      A_DSTEP: w = '{op: OP_DIVSTEP, wait_in: 1'b0, wait_out: 1'b0,
                     cond: C_DIV_MORE,  target: A_DSTEP};
      A_EVAL:  w = '{op: OP_EVAL,    wait_in: 1'b0, wait_out: 1'b1,
                     cond: C_Q_NONZERO, target: A_CHECK};
      A_FLUSH: w = '{op: OP_FLUSH,   wait_in: 1'b0, wait_out: 1'b1,
                     cond: C_ALWAYS,    target: A_IDLE};
      A_PAUSE: w = '{op: OP_PAUSE,   wait_in: 1'b0, wait_out: 1'b1,
                     cond: C_ALWAYS,    target: A_CHECK};
      default: w = '{op: OP_NONE,    wait_in: 1'b0, wait_out: 1'b0,
                     cond: C_ALWAYS,    target: A_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/core/step_pulse_symbol_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse symbol encoder
// Turns a motion command (step count, tick span) into a run of pulse symbols.
// ----------------------------------------------------------------------------
// Each command is loaded in the idle step and closed by a flush step; every
// step symbol runs check, test, divider setup, the divider steps and then
// evaluate, with a one-bit-per-cycle restoring divider that forms
// (span + remainder) / steps for every symbol. A pause (zero step count)
// runs check, test, pause, check and flush; an empty command runs check
// and flush. Each symbol word leaves one step behind the next computed
// one, so the last word of a command carries last_symbol.
// Commands are taken only between commands; a finished word waits in the
// output register without holding up the divider.
`include "assert_macros.svh"

module step_pulse_symbol_encoder
  import spse_pkg::*;
#(
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [STEPS_W-1:0]  step_count_i,
  input  logic [SPAN_W-1:0]   tick_span_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [FIRST_W-1:0]  first_ticks_o,
  output logic                first_level_o,
  output logic [SECOND_W-1:0] second_ticks_o,
  output logic                last_symbol_o
);

  localparam int                 CNT_W    = $clog2(MAX_STEPS + 1);
  localparam logic [STEPS_W-1:0] MAX_STEP = STEPS_W'(MAX_STEPS);
  localparam logic [CNT_W-1:0]   MAX_CNT  = CNT_W'(MAX_STEPS);

  // control registers
  pc_t                  pc_q, pc_d;
  logic [STEPS_W-1:0]   steps_q, steps_d;
  logic [SPAN_W-1:0]    span_q, span_d;
  logic [SPAN_W-1:0]    ticks_q, ticks_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 pend_v_q, pend_v_d;
  logic                 out_valid_q, out_valid_d;

  // payload registers
  logic [DIV_W-1:0]     dq_q, dq_d;
  logic [REM_W-1:0]     dr_q, dr_d;
  logic [FIRST_W-1:0]   pend_first_q, pend_first_d;
  logic                 pend_level_q, pend_level_d;
  logic [SECOND_W-1:0]  pend_second_q, pend_second_d;
  logic [FIRST_W-1:0]   out_first_q, out_first_d;
  logic                 out_level_q, out_level_d;
  logic [SECOND_W-1:0]  out_second_q, out_second_d;
  logic                 out_last_q, out_last_d;

  ctl_word_t            ctl;
  logic                 out_free;
  logic                 go;
  logic                 take;
  logic [SPAN_W-1:0]    left;
  logic                 q_nz;
  logic [SPAN_W-1:0]    sym_dur;
  logic [FIRST_W-1:0]   sym_half;
  logic [SECOND_W-1:0]  sym_second;
  logic                 kept;
  logic [STEPS_W-1:0]   steps_sat;
  logic [REM_W:0]       trial;
  logic [REM_W:0]       trial_sub;
  logic                 trial_ge;

  assign ctl      = ucode(pc_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign go       = (!ctl.wait_in || in_valid_i) && (!ctl.wait_out || !pend_v_q || out_free);

  assign in_stall_o     = !ctl.wait_in;
  assign out_valid_o    = out_valid_q;
  assign first_ticks_o  = out_first_q;
  assign first_level_o  = out_level_q;
  assign second_ticks_o = out_second_q;
  assign last_symbol_o  = out_last_q;

  assign steps_sat = (step_count_i > MAX_STEP) ? MAX_STEP : step_count_i;

  // symbol duration, clamped to the ticks left in the command
  assign left    = span_q - ticks_q;
  assign q_nz    = (dq_q != '0);
  always_comb begin
    if (ctl.op == OP_PAUSE) begin
      sym_dur = left;
    end else if (dq_q > {1'b0, left}) begin
      sym_dur = left;
    end else begin
      sym_dur = dq_q[SPAN_W-1:0];
    end
  end
  assign sym_half   = sym_dur[SPAN_W-1:1];
  assign sym_second = sym_dur - SECOND_W'(sym_half);
  assign kept       = (cnt_q < MAX_CNT);

  // one restoring division step
  assign trial     = {dr_q, dq_q[DIV_W-1]};
  assign trial_ge  = (trial >= {1'b0, steps_q});
  assign trial_sub = trial - {1'b0, steps_q};

  always_comb begin
    case (ctl.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_DONE:      take = (ticks_q >= span_q);
      C_PAUSE:     take = (steps_q == '0);
      C_DIV_MORE:  take = (div_cnt_q != DIV_CNT_W'(1));
      C_Q_NONZERO: take = q_nz;
      default:     take = 1'b1;
    endcase
  end

  always_comb begin
    pc_d          = pc_q;
    steps_d       = steps_q;
    span_d        = span_q;
    ticks_d       = ticks_q;
    rem_d         = rem_q;
    div_cnt_d     = div_cnt_q;
    cnt_d         = cnt_q;
    pend_v_d      = pend_v_q;
    out_valid_d   = out_valid_q && out_stall_i;
    dq_d          = dq_q;
    dr_d          = dr_q;
    pend_first_d  = pend_first_q;
    pend_level_d  = pend_level_q;
    pend_second_d = pend_second_q;
    out_first_d   = out_first_q;
    out_level_d   = out_level_q;
    out_second_d  = out_second_q;
    out_last_d    = out_last_q;

    if (go) begin
      pc_d = take ? ctl.target : pc_q + PC_W'(1);
      case (ctl.op)
        OP_LOAD: begin
          steps_d  = steps_sat;
          span_d   = tick_span_i;
          ticks_d  = '0;
          cnt_d    = '0;
          pend_v_d = 1'b0;
        end
        OP_DIVINIT: begin
          dq_d      = {1'b0, span_q} + DIV_W'(rem_q);
          dr_d      = '0;
          div_cnt_d = DIV_CNT_W'(DIV_W);
        end
        OP_DIVSTEP: begin
          dq_d      = {dq_q[DIV_W-2:0], trial_ge};
          dr_d      = trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
          div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
        end
        OP_EVAL, OP_PAUSE: begin
          if (ctl.op == OP_EVAL && !q_nz) begin
            // zero duration: remainder drops, nothing more in this command
            rem_d = '0;
          end else begin
            if (ctl.op == OP_EVAL) begin
              rem_d   = dr_q;
              ticks_d = ticks_q + sym_dur;
            end else begin
              ticks_d = span_q;
            end
            if (kept) begin
              // release the held word, hold the new one until the next is known
              if (pend_v_q) begin
                out_valid_d  = 1'b1;
                out_first_d  = pend_first_q;
                out_level_d  = pend_level_q;
                out_second_d = pend_second_q;
                out_last_d   = 1'b0;
              end
              pend_v_d      = 1'b1;
              pend_first_d  = sym_half;
              pend_level_d  = (ctl.op == OP_EVAL);
              pend_second_d = sym_second;
              cnt_d         = cnt_q + CNT_W'(1);
            end
          end
        end
        OP_FLUSH: begin
          if (pend_v_q) begin
            out_valid_d  = 1'b1;
            out_first_d  = pend_first_q;
            out_level_d  = pend_level_q;
            out_second_d = pend_second_q;
            out_last_d   = 1'b1;
          end
          pend_v_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= A_IDLE;
      steps_q     <= '0;
      span_q      <= '0;
      ticks_q     <= '0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
      cnt_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      steps_q     <= steps_d;
      span_q      <= span_d;
      ticks_q     <= ticks_d;
      rem_q       <= rem_d;
      div_cnt_q   <= div_cnt_d;
      cnt_q       <= cnt_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q          <= dq_d;
    dr_q          <= dr_d;
    pend_first_q  <= pend_first_d;
    pend_level_q  <= pend_level_d;
    pend_second_q <= pend_second_d;
    out_first_q   <= out_first_d;
    out_level_q   <= out_level_d;
    out_second_q  <= out_second_d;
    out_last_q    <= out_last_d;
  end

  `SPSE_ASSERT(a_ticks_in_span, ticks_q <= span_q, "ticks used exceed command span")
  `SPSE_ASSERT(a_div_cnt_live, pc_q == A_DSTEP |-> div_cnt_q != '0, "divider ran past its last bit")
  `SPSE_ASSERT(a_rem_below_steps, (pc_q == A_EVAL && go) |=> rem_q < steps_q, "remainder not below step count")
  `SPSE_ASSERT(a_cnt_bound, cnt_q <= MAX_CNT, "symbol count beyond limit")
  `SPSE_ASSERT_RST(a_reset_no_word, !rst_ni |=> !out_valid_o, "word valid out of reset")

endmodule
